/* hw/rtl/xoshiro256ss_range_generator_core_defines.svh */
// Assertion macros shared by the generator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef XOSHIRO256SS_RANGE_GENERATOR_CORE_DEFINES_SVH
`define XOSHIRO256SS_RANGE_GENERATOR_CORE_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define XRG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/xrg_pkg.sv */
package xrg_pkg;

	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_RANGE = 2'd1,
		OP_UPPER = 2'd2,
		OP_FRAC  = 2'd3
	} op_t;

	localparam logic [4:0]  WARMUP_STEPS = 5'd16;
	localparam logic [63:0] SEED_WORD1   = 64'h0000_0000_0000_00ff;

	// One classified request as it sits in the queue.
	typedef struct packed {
		op_t         op;
		logic [63:0] seed_first;
		logic [63:0] seed_second;
		logic [63:0] lo;       // lower bound after swap
		logic [63:0] n;        // span, up - low
		logic [63:0] mask;     // smallest all-ones value not below n
		logic        raw_out;  // upper request with up = 0
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic   empty;
		entry_t entry;
	} q_rd_t;

endpackage

/* hw/rtl/xrg_front.sv */
module xrg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          operation,
	input  logic [63:0]         seed_first,
	input  logic [63:0]         seed_second,
	input  logic signed [63:0]  range_low,
	input  logic signed [63:0]  range_high,
	output xrg_pkg::q_wr_t      q_wr,
	input  logic                q_full
);
	import xrg_pkg::*;

	// stage 1: captured request
	logic               v_s1;
	op_t                op_s1;
	logic [63:0]        sf_s1, ss_s1;
	logic signed [63:0] lo_s1, hi_s1;

	// stage 2: swapped bounds and span
	logic               v_s2;
	op_t                op_s2;
	logic [63:0]        sf_s2, ss_s2;
	logic [63:0]        lo_s2, n_s2;
	logic               raw_s2;

	logic        s2_free, s1_move, accept;
	logic        swap;
	logic [63:0] mask;

	assign q_wr.push = v_s2 && !q_full;
	assign s2_free   = !v_s2 || q_wr.push;
	assign s1_move   = v_s1 && s2_free;
	assign full      = v_s1 && !s2_free;
	assign accept    = push && !full;

	assign swap = lo_s1 > hi_s1;

	always_comb begin
		mask = n_s2;
		mask = mask | (mask >> 1);
		mask = mask | (mask >> 2);
		mask = mask | (mask >> 4);
		mask = mask | (mask >> 8);
		mask = mask | (mask >> 16);
		mask = mask | (mask >> 32);
	end

	assign q_wr.entry.op          = op_s2;
	assign q_wr.entry.seed_first  = sf_s2;
	assign q_wr.entry.seed_second = ss_s2;
	assign q_wr.entry.lo          = lo_s2;
	assign q_wr.entry.n           = n_s2;
	assign q_wr.entry.mask        = mask;
	assign q_wr.entry.raw_out     = raw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_t'(operation);
			sf_s1 <= seed_first;
			ss_s1 <= seed_second;
			hi_s1 <= range_high;
			// upper request uses a fixed lower bound of one
			lo_s1 <= (op_t'(operation) == OP_UPPER) ? 64'sd1 : range_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_move) begin
			v_s2 <= 1'b1;
		end else if (q_wr.push) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			op_s2  <= op_s1;
			sf_s2  <= sf_s1;
			ss_s2  <= ss_s1;
			lo_s2  <= swap ? hi_s1 : lo_s1;
			n_s2   <= swap ? (lo_s1 - hi_s1) : (hi_s1 - lo_s1);
			raw_s2 <= (op_s1 == OP_UPPER) && (hi_s1 == 64'sd0);
		end
	end

endmodule

/* hw/rtl/xrg_queue.sv */
module xrg_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  xrg_pkg::q_wr_t  q_wr,
	output logic            q_full,
	input  logic            q_pop,
	output xrg_pkg::q_rd_t  q_rd
);
	import xrg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign q_full      = cnt_q == CW'(DEPTH);
	assign q_rd.empty  = cnt_q == '0;
	assign q_rd.entry  = mem_q[rd_ptr_q];
	assign do_wr       = q_wr.push && !q_full;
	assign do_rd       = q_pop && !q_rd.empty;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

endmodule

/* hw/rtl/xrg_back.sv */
`include "xoshiro256ss_range_generator_core_defines.svh"

module xrg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  xrg_pkg::q_rd_t     q_rd,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] value,
	output logic [52:0]        fraction
);
	import xrg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WARM  = 6'b000010,
		ST_STEP  = 6'b000100,
		ST_MIX   = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t      state_q;
	logic        boot_q;
	logic [4:0]  cnt_q;
	logic [63:0] gen_q [4];
	logic [63:0] gen_nxt [4];
	entry_t      cur_q;
	logic [63:0] t_q, raw_q;
	logic [63:0] res_value_q;
	logic [52:0] res_frac_q;
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [52:0] out_frac_q;

	logic [63:0] w2x, w3x, rot7, masked;
	logic        fits;
	logic        out_load;

	// state update of one generator step
	always_comb begin
		w2x        = gen_q[2] ^ gen_q[0];
		w3x        = gen_q[3] ^ gen_q[1];
		gen_nxt[0] = gen_q[0] ^ w3x;
		gen_nxt[1] = gen_q[1] ^ w2x;
		gen_nxt[2] = w2x ^ (gen_q[1] << 17);
		gen_nxt[3] = {w3x[18:0], w3x[63:19]};
	end

	assign rot7   = {t_q[56:0], t_q[63:57]};
	assign masked = raw_q & cur_q.mask;
	assign fits   = masked <= cur_q.n;

	// finished result moves into the output register
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || pop);

	assign q_pop    = (state_q == ST_IDLE) && !q_rd.empty;
	assign empty    = !out_valid_q;
	assign value    = out_value_q;
	assign fraction = out_frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WARM;
			boot_q      <= 1'b1;
			cnt_q       <= WARMUP_STEPS;
			gen_q[0]    <= '0;
			gen_q[1]    <= SEED_WORD1;
			gen_q[2]    <= '0;
			gen_q[3]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_rd.empty) begin
						if (q_rd.entry.op == OP_SEED) begin
							gen_q[0] <= q_rd.entry.seed_first;
							gen_q[1] <= SEED_WORD1;
							gen_q[2] <= q_rd.entry.seed_second;
							gen_q[3] <= '0;
							cnt_q    <= WARMUP_STEPS;
							state_q  <= ST_WARM;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_WARM: begin
					gen_q <= gen_nxt;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 5'd1) begin
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_STEP: begin
					gen_q   <= gen_nxt;
					t_q     <= gen_q[1] + (gen_q[1] << 2);
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					raw_q   <= rot7 + (rot7 << 3);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((cur_q.op == OP_FRAC) || cur_q.raw_out || fits) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rd.entry;
		end
		if (state_q == ST_IDLE) begin
			res_value_q <= '0;
			res_frac_q  <= '0;
		end else if (state_q == ST_CHECK) begin
			if (cur_q.op == OP_FRAC) begin
				res_value_q <= '0;
				res_frac_q  <= raw_q[63:11];
			end else if (cur_q.raw_out) begin
				res_value_q <= raw_q;
				res_frac_q  <= '0;
			end else begin
				res_value_q <= cur_q.lo + masked;
				res_frac_q  <= '0;
			end
		end
		if (out_load) begin
			out_value_q <= res_value_q;
			out_frac_q  <= res_frac_q;
		end
	end

	`XRG_ASSERT(a_warm_cnt, (state_q != ST_WARM) || (cnt_q != '0), "warm-up with zero count")
	`XRG_ASSERT(a_boot_warm, !boot_q || (state_q == ST_WARM), "request taken before boot warm-up")
	`XRG_ASSERT_NEXT(a_done_hold, (state_q == ST_DONE) && out_valid_q && !pop, (state_q == ST_DONE) && out_valid_q, "finished result overwrote waiting transfer")
	`XRG_ASSERT_NEXT(a_done_load, (state_q == ST_DONE) && (!out_valid_q || pop), out_valid_q && (state_q == ST_IDLE), "finished result not delivered")

endmodule

/* hw/rtl/xoshiro256ss_range_generator_core.sv */
// xoshiro256** generator with range draws. Each request pushed in gives exactly
// one result, in order. Seed loads {first, 0xff, second, 0} and runs sixteen
// warm-up steps (value and fraction zero); range returns low + an unbiased draw
// in 0..up-low (bounds swapped if reversed) by mask-and-reject; upper is range
// with low = 1, or the raw word when up = 0; fraction returns raw >> 11.
// Flow: a request passes the classify stages (capture, then swap and span),
// which overlap the previous request's work. Each back-engine attempt runs
// the states step (state update with w1*5), scramble and accept test, with
// idle and done for handoff; a rejected draw repeats the attempt (fewer than
// one rejection on average). The generator loop sets the request rate: the
// next request is taken only once the last result is in the output register.
// After reset the engine runs the sixteen warm-up steps on a zero seed before
// it takes a request; requests still queue during that time.
module xoshiro256ss_range_generator_core #(
	parameter int QUEUE_DEPTH = 2  // classified requests buffered between front and back
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [63:0]        seed_first,
	input  logic [63:0]        seed_second,
	input  logic signed [63:0] range_low,
	input  logic signed [63:0] range_high,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] value,
	output logic [52:0]        fraction
);
	import xrg_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	// front: captures requests, swaps bounds, computes span and mask
	xrg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.seed_first  (seed_first),
		.seed_second (seed_second),
		.range_low   (range_low),
		.range_high  (range_high),
		.q_wr        (q_wr),
		.q_full      (q_full)
	);

	// short queue decoupling the two halves
	xrg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_rd   (q_rd)
	);

	// back: generator state, rejection loop and output register
	xrg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.value    (value),
		.fraction (fraction)
	);

endmodule
